>>> rtl/vector_magnitude_running_stats_top_defines.svh
// Assertion macros for the vector magnitude statistics block.
`ifndef VECTOR_MAGNITUDE_RUNNING_STATS_TOP_DEFINES_SVH
`define VECTOR_MAGNITUDE_RUNNING_STATS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define VMRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VMRS_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VMRS_ASSERT(label, clk, rst_n, prop)
`define VMRS_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/vmrs_pkg.sv
`default_nettype none
package vmrs_pkg;
    localparam int unsigned RegCount = 5;
    localparam logic [2:0] REG_USE_FILTERED = 3'd0;
    localparam logic [2:0] REG_ENABLE_MEAN  = 3'd1;
    localparam logic [2:0] REG_ENABLE_RMS   = 3'd2;
    localparam logic [2:0] REG_ENABLE_PEAK  = 3'd3;
    localparam logic [2:0] REG_ENABLE_RATE  = 3'd4;
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam logic [16:0] RATE_NUMERATOR = 17'd100000;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [15:0] mean_value;
        logic [15:0] rms_value;
        logic [15:0] peak_value;
        logic [16:0] rate_centihertz;
        logic [31:0] sample_total;
    } result_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_t;
endpackage
`default_nettype wire

>>> rtl/vmrs_if.sv
`default_nettype none
interface vmrs_if #(
    parameter int unsigned PAYLOAD_BITS = 8
) ();
    logic                    valid;
    logic                    ready;
    logic [PAYLOAD_BITS-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/vector_magnitude_running_stats_top.sv
// One sample item at a time. A sample is squared one component at a time,
// then passes through shared 64-bit restoring division and root-step logic:
// the magnitude root, the mean division, the rms division and its root and
// the rate division, in that order; a disabled statistic, or a zero count or
// interval, skips its stage. A clear item resets the statistics and goes
// straight to ST_OUT, which registers the result. The next item can be
// accepted in the cycle after the result is taken. Input payload packs, from
// the top, command, calibrated x/y/z, filtered x/y/z and time_ms; the result
// payload is vmrs_pkg::result_t. Configuration writes carry vmrs_pkg::cfg_t.
`default_nettype none
`include "vector_magnitude_running_stats_top_defines.svh"
module vector_magnitude_running_stats_top #(
    parameter int unsigned COMPONENT_BITS = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vmrs_if.sink      cfg,
    vmrs_if.sink      in_item,
    vmrs_if.source    out_item
);
    localparam int unsigned SqBits = 2 * COMPONENT_BITS + 2;
    localparam int unsigned MagBits = COMPONENT_BITS + 1;
    localparam int unsigned CB = COMPONENT_BITS;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_MAG, ST_MEAN_DIV, ST_RMS_DIV, ST_RMS_ROOT,
        ST_RATE_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic use_filtered_reg, enable_mean_reg, enable_rms_reg;
    logic enable_peak_reg, enable_rate_reg;
    logic [COUNT_BITS-1:0] sample_counter_reg;
    logic [47:0] magnitude_sum_reg;
    logic [63:0] square_sum_reg;
    logic [15:0] peak_held_reg, mean_held_reg, rms_held_reg;
    logic [31:0] last_time_reg;
    logic [16:0] rate_held_reg;
    logic        out_valid_reg;
    vmrs_pkg::result_t out_reg;
    logic [CB-1:0] vx_reg, vy_reg, vz_reg;
    logic [1:0]    sq_step_reg;
    logic [SqBits-1:0] sq_acc_reg;
    logic [31:0]   now_reg;
    logic [63:0]   rem_reg, quo_reg, den_reg, work_reg;
    logic [6:0]    step_reg;
    logic [15:0]   mag_reg;

    logic [6*CB+32:0] in_pl;
    logic [CB-1:0] in_cx, in_cy, in_cz, in_fx, in_fy, in_fz;
    logic [31:0]   in_time;
    logic          in_cmd;
    assign in_pl   = in_item.payload;
    assign in_time = in_pl[31:0];
    assign in_fz   = in_pl[32 +: CB];
    assign in_fy   = in_pl[32 + CB +: CB];
    assign in_fx   = in_pl[32 + 2*CB +: CB];
    assign in_cz   = in_pl[32 + 3*CB +: CB];
    assign in_cy   = in_pl[32 + 4*CB +: CB];
    assign in_cx   = in_pl[32 + 5*CB +: CB];
    assign in_cmd  = in_pl[32 + 6*CB];

    vmrs_pkg::cfg_t cfg_w;
    assign cfg_w = cfg.payload;
    assign cfg.ready = 1'b1;
    assign in_item.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_item.valid = out_valid_reg;
    assign out_item.payload = out_reg;

    // Shared unit: square of one component (mux), and restoring division or
    // root step on 64 bits.
    logic [CB-1:0] sq_sel, sq_abs;
    logic [2*CB-1:0] sq_prod;
    always_comb
    begin
        case (sq_step_reg)
            2'd0: sq_sel = vx_reg;
            2'd1: sq_sel = vy_reg;
            default: sq_sel = vz_reg;
        endcase
        sq_abs = sq_sel[CB-1] ? (~sq_sel + 1'b1) : sq_sel;
        sq_prod = sq_abs * sq_abs;
    end

    // Division step: shift remainder left with next dividend bit.
    logic [64:0] div_shift;
    logic [64:0] div_diff;
    assign div_shift = {rem_reg, work_reg[63]};
    assign div_diff  = div_shift - {1'b0, den_reg};
    // Root step: den_reg holds bit, quo_reg root, work_reg n.
    logic [64:0] root_try;
    assign root_try = {1'b0, quo_reg} + {1'b0, den_reg};

    logic [63:0] div_q;
    assign div_q = {quo_reg[62:0], ~div_diff[64]};
    logic [31:0] dt;
    assign dt = now_reg - last_time_reg;
    logic [63:0] cnt64;
    assign cnt64 = 64'(sample_counter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            use_filtered_reg <= 1'b1;
            enable_mean_reg <= 1'b1;
            enable_rms_reg <= 1'b1;
            enable_peak_reg <= 1'b1;
            enable_rate_reg <= 1'b1;
            sample_counter_reg <= '0;
            magnitude_sum_reg <= '0;
            square_sum_reg <= '0;
            peak_held_reg <= '0;
            mean_held_reg <= '0;
            rms_held_reg <= '0;
            last_time_reg <= '0;
            rate_held_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_w.index)
                    vmrs_pkg::REG_USE_FILTERED: use_filtered_reg <= cfg_w.data[0];
                    vmrs_pkg::REG_ENABLE_MEAN:  enable_mean_reg <= cfg_w.data[0];
                    vmrs_pkg::REG_ENABLE_RMS:   enable_rms_reg <= cfg_w.data[0];
                    vmrs_pkg::REG_ENABLE_PEAK:  enable_peak_reg <= cfg_w.data[0];
                    vmrs_pkg::REG_ENABLE_RATE:  enable_rate_reg <= cfg_w.data[0];
                    default: ;
                endcase
            end
            if (out_item.valid && out_item.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_item.valid && !out_valid_reg)
                    begin
                        now_reg <= in_time;
                        if (in_cmd == vmrs_pkg::CMD_CLEAR)
                        begin
                            sample_counter_reg <= '0;
                            magnitude_sum_reg <= '0;
                            square_sum_reg <= '0;
                            peak_held_reg <= '0;
                            mean_held_reg <= '0;
                            rms_held_reg <= '0;
                            rate_held_reg <= '0;
                            last_time_reg <= in_time;
                            mag_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            vx_reg <= use_filtered_reg ? in_fx : in_cx;
                            vy_reg <= use_filtered_reg ? in_fy : in_cy;
                            vz_reg <= use_filtered_reg ? in_fz : in_cz;
                            sq_step_reg <= 2'd0;
                            sq_acc_reg <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    sq_acc_reg <= sq_acc_reg + SqBits'(sq_prod);
                    sq_step_reg <= sq_step_reg + 2'd1;
                    if (sq_step_reg == 2'd2)
                    begin
                        work_reg <= 64'(sq_acc_reg + SqBits'(sq_prod));
                        quo_reg <= '0;
                        den_reg <= 64'd1 << 62;
                        state_reg <= ST_MAG;
                    end
                end
                ST_MAG, ST_RMS_ROOT:
                begin
                    if (den_reg == 64'd0)
                    begin
                        if (state_reg == ST_MAG)
                        begin
                            mag_reg <= quo_reg[15:0];
                            if (sample_counter_reg != CountMax)
                                sample_counter_reg <= sample_counter_reg + 1'b1;
                            if (enable_peak_reg && quo_reg[15:0] > peak_held_reg)
                                peak_held_reg <= quo_reg[15:0];
                            if (enable_mean_reg && sample_counter_reg != CountMax)
                                magnitude_sum_reg <= magnitude_sum_reg
                                    + 48'(quo_reg[MagBits-1:0]);
                            if (enable_rms_reg && sample_counter_reg != CountMax)
                                square_sum_reg <= square_sum_reg
                                    + 64'(quo_reg[MagBits-1:0]) * 64'(quo_reg[MagBits-1:0]);
                            state_reg <= ST_MEAN_DIV;
                            step_reg <= '0;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            work_reg <= '0;
                        end
                        else
                        begin
                            rms_held_reg <= quo_reg[15:0];
                            state_reg <= ST_RATE_DIV;
                            step_reg <= '0;
                            rem_reg <= '0;
                            quo_reg <= '0;
                        end
                    end
                    else if (!root_try[64] && work_reg >= root_try[63:0])
                    begin
                        work_reg <= work_reg - root_try[63:0];
                        quo_reg <= (quo_reg >> 1) + den_reg;
                        den_reg <= den_reg >> 2;
                    end
                    else
                    begin
                        quo_reg <= quo_reg >> 1;
                        den_reg <= den_reg >> 2;
                    end
                end
                ST_MEAN_DIV, ST_RMS_DIV, ST_RATE_DIV:
                begin
                    if (step_reg == 7'd0)
                    begin
                        step_reg <= 7'd1;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        if (state_reg == ST_MEAN_DIV)
                        begin
                            work_reg <= 64'(magnitude_sum_reg);
                            den_reg <= cnt64;
                            if (!enable_mean_reg || cnt64 == 0)
                            begin
                                state_reg <= ST_RMS_DIV;
                                step_reg <= '0;
                            end
                        end
                        else if (state_reg == ST_RMS_DIV)
                        begin
                            work_reg <= square_sum_reg;
                            den_reg <= cnt64;
                            if (!enable_rms_reg || cnt64 == 0)
                            begin
                                state_reg <= ST_RATE_DIV;
                                step_reg <= '0;
                            end
                        end
                        else
                        begin
                            work_reg <= {32'(vmrs_pkg::RATE_NUMERATOR), 32'd0};
                            den_reg <= 64'(dt);
                            if (!enable_rate_reg)
                                state_reg <= ST_OUT;
                            else if (dt == 0)
                            begin
                                last_time_reg <= now_reg;
                                state_reg <= ST_OUT;
                            end
                        end
                    end
                    else
                    begin
                        rem_reg <= div_diff[64] ? div_shift[63:0] : div_diff[63:0];
                        quo_reg <= div_q;
                        work_reg <= work_reg << 1;
                        step_reg <= step_reg + 1'b1;
                        if (state_reg == ST_RATE_DIV ? step_reg == 7'd32
                                                     : step_reg == 7'd64)
                        begin
                            step_reg <= '0;
                            if (state_reg == ST_MEAN_DIV)
                            begin
                                mean_held_reg <= div_q[15:0];
                                state_reg <= ST_RMS_DIV;
                            end
                            else if (state_reg == ST_RMS_DIV)
                            begin
                                work_reg <= div_q;
                                quo_reg <= '0;
                                den_reg <= 64'd1 << 62;
                                state_reg <= ST_RMS_ROOT;
                            end
                            else
                            begin
                                rate_held_reg <= div_q[16:0];
                                last_time_reg <= now_reg;
                                state_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_OUT:
                begin
                    out_reg.magnitude <= mag_reg;
                    out_reg.mean_value <= mean_held_reg;
                    out_reg.rms_value <= rms_held_reg;
                    out_reg.peak_value <= peak_held_reg;
                    out_reg.rate_centihertz <= rate_held_reg;
                    out_reg.sample_total <= 32'(sample_counter_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `VMRS_ASSERT(a_busy_not_ready, clk, rst_n,
        (state_reg != ST_IDLE) |-> !in_item.ready)
    `VMRS_ASSERT(a_out_after_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
    `VMRS_ASSERT(a_count_bounded, clk, rst_n,
        (state_reg == ST_IDLE) |=> (sample_counter_reg == $past(sample_counter_reg)
            || sample_counter_reg == '0))
    `VMRS_ASSERT_RST(a_reset_idle, clk, !rst_n |-> state_reg == ST_IDLE)
endmodule
`default_nettype wire

>>> sim/tb_vector_magnitude_running_stats_top.sv
`timescale 1ns / 1ps
module tb_vector_magnitude_running_stats_top;

    localparam int unsigned SAMPLE_BITS = 129;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_ITEMS = 165;

    typedef struct {
        logic        command;
        logic [15:0] cal_x;
        logic [15:0] cal_y;
        logic [15:0] cal_z;
        logic [15:0] fil_x;
        logic [15:0] fil_y;
        logic [15:0] fil_z;
        logic [31:0] stamp;
        bit          typed;
        vmrs_pkg::result_t known;
    } directed_row_t;

    logic clk;
    logic rst_n;

    vmrs_if #(.PAYLOAD_BITS(35)) cfg_ch ();
    vmrs_if #(.PAYLOAD_BITS(SAMPLE_BITS)) in_ch ();
    vmrs_if #(.PAYLOAD_BITS($bits(vmrs_pkg::result_t))) out_ch ();

    vector_magnitude_running_stats_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch.sink),
        .in_item  (in_ch.sink),
        .out_item (out_ch.source)
    );

    // Copy of the block's settings and statistics.
    logic        sel_filtered;
    logic        mean_on;
    logic        rms_on;
    logic        peak_on;
    logic        rate_on;
    logic [31:0] count_now;
    logic [47:0] mag_total;
    logic [63:0] square_total;
    logic [15:0] peak_now;
    logic [31:0] stamp_prev;
    logic [16:0] rate_now;
    logic [15:0] mean_now;
    logic [15:0] rms_now;

    vmrs_pkg::result_t pending_stats[$];
    int unsigned fault_count;
    bit          hold_output;

    directed_row_t directed_rows[] = '{
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b1, '{0, 0, 0, 0, 0, 1}},
        '{vmrs_pkg::CMD_CLEAR, 16'h1234, 16'h8000, 16'h7fff, 16'hffff, 16'h0001,
          16'h8000, 32'd100, 1'b1, '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 32'd101, 1'b1,
          '{16'd56755, 16'd56755, 16'd56755, 16'd56755, 17'd100000, 32'd1}},
        '{vmrs_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 32'd101, 1'b0, '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 16'h7fff, 0, 0, 16'hffff, 0, 0, 32'd102, 1'b0,
          '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 16'h0003, 16'hfffc, 16'h000c, 32'd1102, 1'b0,
          '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 16'h5555, 16'haaaa, 16'h0f0f, 16'h8001, 16'h7ffe,
          16'h4000, 32'hffff_ffff, 1'b0, '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 16'h0000, 16'h0000, 16'h8000, 32'd0, 1'b0,
          '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'hffff_ff00, 1'b1,
          '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 16'hffff, 16'hffff, 16'hffff, 16'h0003, 16'h0004,
          16'h0000, 32'd0, 1'b1, '{16'd5, 16'd5, 16'd5, 16'd5, 17'd390, 32'd1}},
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 16'h0001, 16'h0000, 16'h0000, 32'd1, 1'b0,
          '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 0, 0, 0, 16'h2000, 16'he000, 16'h2000, 32'h8000_0001,
          1'b0, '{0, 0, 0, 0, 0, 0}},
        '{vmrs_pkg::CMD_SAMPLE, 16'h00ff, 16'hff00, 16'hf0f0, 16'h8000, 16'h7fff,
          16'h0000, 32'h8000_0033, 1'b0, '{0, 0, 0, 0, 0, 0}}
    };

    always #5 clk = ~clk;

    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [16:0] axis_size(input logic [15:0] raw);
        return raw[15] ? 17'(-$signed({raw[15], raw})) : {1'b0, raw};
    endfunction

    function automatic vmrs_pkg::result_t predict_stats(input logic [SAMPLE_BITS-1:0] p);
        vmrs_pkg::result_t r;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] az;
        logic [63:0] mag;
        logic [31:0] dt;
        logic        counting;
        mag = '0;
        if (p[128] == vmrs_pkg::CMD_CLEAR) begin
            count_now = '0;
            mag_total = '0;
            square_total = '0;
            peak_now = '0;
            rate_now = '0;
            mean_now = '0;
            rms_now = '0;
            stamp_prev = p[31:0];
        end else begin
            ax = axis_size(sel_filtered ? p[79:64] : p[127:112]);
            ay = axis_size(sel_filtered ? p[63:48] : p[111:96]);
            az = axis_size(sel_filtered ? p[47:32] : p[95:80]);
            mag = 64'(floor_root(64'(ax) * ax + 64'(ay) * ay + 64'(az) * az));
            counting = count_now != 32'hffff_ffff;
            if (counting)
                count_now++;
            if (mean_on) begin
                if (counting)
                    mag_total = mag_total + 48'(mag);
                if (count_now != 0)
                    mean_now = 16'(64'(mag_total) / count_now);
            end
            if (rms_on) begin
                if (counting)
                    square_total = square_total + mag * mag;
                if (count_now != 0)
                    rms_now = 16'(floor_root(square_total / count_now));
            end
            if (peak_on && mag[15:0] > peak_now)
                peak_now = mag[15:0];
            if (rate_on) begin
                dt = p[31:0] - stamp_prev;
                stamp_prev = p[31:0];
                if (dt != 0)
                    rate_now = 17'(32'd100000 / dt);
            end
        end
        r.magnitude = mag[15:0];
        r.mean_value = mean_now;
        r.rms_value = rms_now;
        r.peak_value = peak_now;
        r.rate_centihertz = rate_now;
        r.sample_total = count_now;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] p, input bit typed,
                               input vmrs_pkg::result_t known);
        vmrs_pkg::result_t predicted;
        int unsigned gap;
        in_ch.valid <= 1'b1;
        in_ch.payload <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = predict_stats(p);
        pending_stats.push_back(typed ? known : predicted);
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_setting(input logic [2:0] index, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= {index, data};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (index)
            vmrs_pkg::REG_USE_FILTERED: sel_filtered = data[0];
            vmrs_pkg::REG_ENABLE_MEAN: mean_on = data[0];
            vmrs_pkg::REG_ENABLE_RMS: rms_on = data[0];
            vmrs_pkg::REG_ENABLE_PEAK: peak_on = data[0];
            vmrs_pkg::REG_ENABLE_RATE: rate_on = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [SAMPLE_BITS-1:0] p;
        logic [31:0]            stamp;
        logic [4:0]             settings;
        directed_row_t          row;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        fault_count = 0;
        hold_output = 1'b0;
        sel_filtered = 1'b1;
        mean_on = 1'b1;
        rms_on = 1'b1;
        peak_on = 1'b1;
        rate_on = 1'b1;
        count_now = '0;
        mag_total = '0;
        square_total = '0;
        peak_now = '0;
        stamp_prev = '0;
        rate_now = '0;
        mean_now = '0;
        rms_now = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_sample({row.command, row.cal_x, row.cal_y, row.cal_z, row.fil_x,
                         row.fil_y, row.fil_z, row.stamp}, row.typed, row.known);
        end

        stamp = 32'd5000;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            case (ph)
                0: settings = 5'b00000;
                1: settings = 5'b11111;
                2: settings = 5'b11110;
                default: settings = 5'($urandom);
            endcase
            write_setting(vmrs_pkg::REG_USE_FILTERED, {31'($urandom), settings[0]});
            write_setting(vmrs_pkg::REG_ENABLE_MEAN, {31'($urandom), settings[1]});
            write_setting(vmrs_pkg::REG_ENABLE_RMS, {31'($urandom), settings[2]});
            write_setting(vmrs_pkg::REG_ENABLE_PEAK, {31'($urandom), settings[3]});
            write_setting(vmrs_pkg::REG_ENABLE_RATE, {31'($urandom), settings[4]});
            if (ph == 3)
                write_setting(3'($urandom_range(5, 7)), $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 20)
                    hold_output = 1'b1;
                if (ph == 4 && n == 80) begin
                    in_ch.valid <= 1'b0;
                    while (pending_stats.size() != 0)
                        @(posedge clk);
                end
                case ($urandom_range(0, 19))
                    0: stamp = $urandom;
                    1: stamp = stamp;
                    2: stamp = stamp + $urandom_range(1000, 200000);
                    default: stamp = stamp + $urandom_range(0, 40);
                endcase
                p = {($urandom_range(0, 29) == 0) ? vmrs_pkg::CMD_CLEAR
                                                  : vmrs_pkg::CMD_SAMPLE,
                     random_axis(), random_axis(), random_axis(),
                     random_axis(), random_axis(), random_axis(), stamp};
                send_sample(p, 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fault_count == 0)
            $display("vector_magnitude_running_stats_top regression: pass");
        else
            $display("vector_magnitude_running_stats_top regression: fail");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_output) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_output = 1'b0;
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if ($urandom_range(0, 19) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 300)) @(posedge clk);
            end else if ($urandom_range(0, 1) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        vmrs_pkg::result_t got;
        vmrs_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected result items", 32'd1, 32'd0);
            end else begin
                want = pending_stats.pop_front();
                if (got.magnitude !== want.magnitude)
                    report_mismatch("magnitude", got.magnitude, want.magnitude);
                if (got.mean_value !== want.mean_value)
                    report_mismatch("mean_value", got.mean_value, want.mean_value);
                if (got.rms_value !== want.rms_value)
                    report_mismatch("rms_value", got.rms_value, want.rms_value);
                if (got.peak_value !== want.peak_value)
                    report_mismatch("peak_value", got.peak_value, want.peak_value);
                if (got.rate_centihertz !== want.rate_centihertz)
                    report_mismatch("rate_centihertz", got.rate_centihertz,
                                    want.rate_centihertz);
                if (got.sample_total !== want.sample_total)
                    report_mismatch("sample_total", got.sample_total, want.sample_total);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("vector_magnitude_running_stats_top regression: fail");
        $finish;
    end
endmodule
